FILE: design/lpn_pkg.sv
`default_nettype none

package lpn_pkg;

    // field widths
    localparam int IDX_W   = 5;
    localparam int PWR_W   = 32;
    localparam int DB_W    = 16;
    localparam int NORM_W  = 16;
    localparam int ALPHA_W = 17;
    localparam int MEAN_W  = 32;

    // per-feature store
    localparam int FEATURE_COUNT = 32;

    // output queue
    localparam int FIFO_DEPTH = 16;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // apb
    localparam int CFG_ADDR_W = 3;
    localparam logic REG_ALPHA = 1'b0;

    // arithmetic constants
    localparam logic [ALPHA_W-1:0]       ALPHA_ONE  = 17'h10000;
    localparam logic signed [MEAN_W-1:0] MEAN_RESET = -32'sd3932160;
    localparam logic signed [DB_W-1:0]   ZERO_DB    = -16'sd25600;
    localparam logic signed [18:0]       DB_PER_OCT = 19'sd197283;
    localparam logic [19:0]              RECIP5     = 20'd838861;
    localparam logic [32:0]              SAT_MAG    = 33'd10485600;
    localparam logic signed [NORM_W-1:0] NORM_MAX   = 16'sd32767;
    localparam logic signed [NORM_W-1:0] NORM_MIN   = -16'sd32768;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
    } t_tag;

    typedef struct packed {
        logic                   valid;
        logic [IDX_W-1:0]       idx;
        logic signed [DB_W-1:0] db;
    } t_log_res;

    typedef struct packed {
        logic                     valid;
        logic [IDX_W-1:0]         idx;
        logic signed [DB_W-1:0]   db;
        logic signed [MEAN_W-1:0] upd;
    } t_mean_res;

    typedef struct packed {
        logic [IDX_W-1:0]         idx;
        logic signed [NORM_W-1:0] norm;
        logic signed [DB_W-1:0]   db;
    } t_out_item;

    // log2(1 + i/16) in q16
    function automatic logic [16:0] lpn_log2_tab(input logic [4:0] i);
        logic [16:0] v;
        unique case (i)
            5'd0:    v = 17'd0;
            5'd1:    v = 17'd5732;
            5'd2:    v = 17'd11136;
            5'd3:    v = 17'd16248;
            5'd4:    v = 17'd21098;
            5'd5:    v = 17'd25711;
            5'd6:    v = 17'd30109;
            5'd7:    v = 17'd34312;
            5'd8:    v = 17'd38336;
            5'd9:    v = 17'd42196;
            5'd10:   v = 17'd45904;
            5'd11:   v = 17'd49472;
            5'd12:   v = 17'd52911;
            5'd13:   v = 17'd56229;
            5'd14:   v = 17'd59434;
            5'd15:   v = 17'd62534;
            5'd16:   v = 17'd65536;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: design/lpn_ram.sv
`default_nettype none

module lpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: design/lpn_log.sv
`default_nettype none

module lpn_log
    import lpn_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [IDX_W-1:0] i_idx,
    input  wire logic [PWR_W-1:0] i_power,
    output t_tag                  o_head,
    output t_log_res              o_res
);

    // stage 1: normalize and table lookup
    logic             r_v1;
    logic [IDX_W-1:0] r_idx1;
    logic [PWR_W-1:0] r_pwr1;
    logic [PWR_W-1:0] w_m;
    logic [4:0]       w_sh;
    logic [16:0]      w_lo;
    logic [16:0]      w_hi;
    logic [16:0]      w_step;

    // stage 2: interpolation product
    logic             r_v2;
    logic [IDX_W-1:0] r_idx2;
    logic             r_zero2;
    logic [4:0]       r_e2;
    logic [15:0]      r_base2;
    logic [12:0]      r_diff2;
    logic [15:0]      r_f2;
    logic [28:0]      w_ip;

    // stage 3: log2 in q16
    logic             r_v3;
    logic [IDX_W-1:0] r_idx3;
    logic             r_zero3;
    logic [4:0]       r_e3;
    logic [15:0]      r_base3;
    logic [12:0]      r_ip3;
    logic [16:0]      w_frac;
    logic signed [5:0]  w_exp;
    logic signed [22:0] w_l;

    // stage 4: scale to db
    logic               r_v4;
    logic [IDX_W-1:0]   r_idx4;
    logic               r_zero4;
    logic signed [22:0] r_l4;
    logic signed [41:0] w_lp;

    // stage 5: round
    logic               r_v5;
    logic [IDX_W-1:0]   r_idx5;
    logic               r_zero5;
    logic signed [41:0] r_lp5;
    logic signed [41:0] w_rnd;

    always_comb begin
        w_m  = r_pwr1;
        w_sh = '0;
        if (w_m[31:16] == 16'h0) begin
            w_m     = w_m << 16;
            w_sh[4] = 1'b1;
        end
        if (w_m[31:24] == 8'h0) begin
            w_m     = w_m << 8;
            w_sh[3] = 1'b1;
        end
        if (w_m[31:28] == 4'h0) begin
            w_m     = w_m << 4;
            w_sh[2] = 1'b1;
        end
        if (w_m[31:30] == 2'h0) begin
            w_m     = w_m << 2;
            w_sh[1] = 1'b1;
        end
        if (!w_m[31]) begin
            w_m     = w_m << 1;
            w_sh[0] = 1'b1;
        end
    end

    assign w_lo   = lpn_log2_tab({1'b0, w_m[30:27]});
    assign w_hi   = lpn_log2_tab({1'b0, w_m[30:27]} + 5'd1);
    assign w_step = w_hi - w_lo;

    assign w_ip = 29'(r_diff2) * 29'(r_f2);

    assign w_frac = {1'b0, r_base3} + {4'h0, r_ip3};
    assign w_exp  = $signed({1'b0, r_e3}) - 6'sd24;
    assign w_l    = {w_exp[5], w_exp, 16'h0000} + {6'h00, w_frac};

    assign w_lp = 42'(r_l4) * 42'(DB_PER_OCT);

    assign w_rnd = r_lp5 + 42'sd8388608;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx1  <= i_idx;
        r_pwr1  <= i_power;

        r_idx2  <= r_idx1;
        r_zero2 <= (r_pwr1 == '0);
        r_e2    <= ~w_sh;
        r_base2 <= w_lo[15:0];
        r_diff2 <= w_step[12:0];
        r_f2    <= w_m[26:11];

        r_idx3  <= r_idx2;
        r_zero3 <= r_zero2;
        r_e3    <= r_e2;
        r_base3 <= r_base2;
        r_ip3   <= w_ip[28:16];

        r_idx4  <= r_idx3;
        r_zero4 <= r_zero3;
        r_l4    <= w_l;

        r_idx5  <= r_idx4;
        r_zero5 <= r_zero4;
        r_lp5   <= w_lp;
    end

    assign o_head.valid = r_v1;
    assign o_head.idx   = r_idx1;

    assign o_res.valid = r_v5;
    assign o_res.idx   = r_idx5;
    assign o_res.db    = r_zero5 ? ZERO_DB : $signed(w_rnd[39:24]);

endmodule

`default_nettype wire

FILE: design/lpn_mean.sv
`default_nettype none

module lpn_mean
    import lpn_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [ALPHA_W-1:0] i_alpha,
    input  wire t_log_res           i_log,
    output t_mean_res               o_res
);

    logic [FEATURE_COUNT-1:0] r_vld;
    logic [MEAN_W-1:0]        w_rdata;

    // stage 6: mean select and products
    logic                     r_v6;
    logic [IDX_W-1:0]         r_idx6;
    logic signed [DB_W-1:0]   r_db6;
    logic                     r_rvld6;
    logic signed [MEAN_W-1:0] w_mean;
    logic [ALPHA_W-1:0]       w_keep;
    logic [ALPHA_W-1:0]       w_gain;
    logic signed [23:0]       w_lv;
    logic signed [41:0]       w_pl;
    logic signed [49:0]       w_pm;

    // stage 7: sum and round
    logic                     r_v7;
    logic [IDX_W-1:0]         r_idx7;
    logic signed [DB_W-1:0]   r_db7;
    logic signed [41:0]       r_pl7;
    logic signed [49:0]       r_pm7;
    logic signed [49:0]       w_sum;

    // stage 8: write back; stage 9 kept for forwarding
    logic                     r_v8;
    logic [IDX_W-1:0]         r_idx8;
    logic signed [DB_W-1:0]   r_db8;
    logic signed [MEAN_W-1:0] r_upd8;
    logic                     r_v9;
    logic [IDX_W-1:0]         r_idx9;
    logic signed [MEAN_W-1:0] r_upd9;

    lpn_ram #(
        .WIDTH (MEAN_W),
        .DEPTH (FEATURE_COUNT)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (r_v8),
        .i_waddr (r_idx8),
        .i_wdata (r_upd8),
        .i_raddr (i_log.idx),
        .o_rdata (w_rdata)
    );

    // newest in-flight update wins, then the store, then the reset value
    always_comb begin
        priority if (r_v8 && (r_idx8 == r_idx6)) begin
            w_mean = r_upd8;
        end else if (r_v9 && (r_idx9 == r_idx6)) begin
            w_mean = r_upd9;
        end else if (r_rvld6) begin
            w_mean = $signed(w_rdata);
        end else begin
            w_mean = MEAN_RESET;
        end
    end

    assign w_keep = i_alpha[ALPHA_W-1] ? ALPHA_ONE : i_alpha;
    assign w_gain = ALPHA_ONE - w_keep;
    assign w_lv   = {r_db6, 8'h00};
    assign w_pl   = 42'(w_lv) * 42'($signed({1'b0, w_gain}));
    assign w_pm   = 50'(w_mean) * 50'($signed({1'b0, w_keep}));

    assign w_sum = r_pm7 + 50'(r_pl7) + 50'sd32768;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_v6  <= 1'b0;
            r_v7  <= 1'b0;
            r_v8  <= 1'b0;
            r_v9  <= 1'b0;
        end else begin
            if (r_v8) begin
                r_vld[r_idx8] <= 1'b1;
            end
            r_v6 <= i_log.valid;
            r_v7 <= r_v6;
            r_v8 <= r_v7;
            r_v9 <= r_v8;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx6  <= i_log.idx;
        r_db6   <= i_log.db;
        r_rvld6 <= r_vld[i_log.idx];

        r_idx7  <= r_idx6;
        r_db7   <= r_db6;
        r_pl7   <= w_pl;
        r_pm7   <= w_pm;

        r_idx8  <= r_idx7;
        r_db8   <= r_db7;
        r_upd8  <= w_sum[47:16];

        r_idx9  <= r_idx8;
        r_upd9  <= r_upd8;
    end

    assign o_res.valid = r_v8;
    assign o_res.idx   = r_idx8;
    assign o_res.db    = r_db8;
    assign o_res.upd   = r_upd8;

endmodule

`default_nettype wire

FILE: design/lpn_scale.sv
`default_nettype none

module lpn_scale
    import lpn_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_mean_res i_mean,
    output logic           o_valid,
    output t_out_item      o_item
);

    logic signed [32:0] w_d;
    logic [32:0]        w_mag;
    logic [24:0]        w_x;

    // stage 9: reciprocal multiply for divide by five
    logic                   r_v9;
    logic [IDX_W-1:0]       r_idx9;
    logic signed [DB_W-1:0] r_db9;
    logic                   r_neg9;
    logic                   r_big9;
    logic [18:0]            r_y9;
    logic [38:0]            w_qp;

    // stage 10: sign and saturate
    logic                     r_v10;
    logic [IDX_W-1:0]         r_idx10;
    logic signed [DB_W-1:0]   r_db10;
    logic                     r_neg10;
    logic                     r_big10;
    logic [38:0]              r_qp10;
    logic signed [NORM_W-1:0] w_q;
    logic signed [NORM_W-1:0] w_norm;

    // divide by 320 as shift by 6 then divide by 5, halves away from zero
    assign w_d   = 33'($signed({i_mean.db, 8'h00})) - 33'(i_mean.upd);
    assign w_mag = w_d[32] ? 33'(-w_d) : 33'(w_d);
    assign w_x   = {1'b0, w_mag[23:0]} + 25'd160;

    assign w_qp = 39'(r_y9) * 39'(RECIP5);

    assign w_q = $signed(r_qp10[37:22]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v9  <= 1'b0;
            r_v10 <= 1'b0;
        end else begin
            r_v9  <= i_mean.valid;
            r_v10 <= r_v9;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx9  <= i_mean.idx;
        r_db9   <= i_mean.db;
        r_neg9  <= w_d[32];
        r_big9  <= (w_mag >= SAT_MAG);
        r_y9    <= w_x[24:6];

        r_idx10 <= r_idx9;
        r_db10  <= r_db9;
        r_neg10 <= r_neg9;
        r_big10 <= r_big9;
        r_qp10  <= w_qp;
    end

    always_comb begin
        priority if (r_big10) begin
            w_norm = r_neg10 ? NORM_MIN : NORM_MAX;
        end else if (r_neg10) begin
            w_norm = -w_q;
        end else begin
            w_norm = w_q;
        end
    end

    assign o_valid     = r_v10;
    assign o_item.idx  = r_idx10;
    assign o_item.norm = w_norm;
    assign o_item.db   = r_db10;

endmodule

`default_nettype wire

FILE: design/log_power_running_mean_normalizer_top.sv
// path: an accepted beat passes the log, mean and scale stages and the output queue
// throughput: one beat per cycle while queue credit is free; a beat with the
//   same index as the previous beat is held back (mean read-modify-write loop)
// reset: synchronous active low; every feature mean reads as -60 dB, alpha is 1.0,
//   and the output queue is empty; no clearing pass is needed
`default_nettype none

module log_power_running_mean_normalizer_top
    import lpn_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,

    // input beats
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic [IDX_W-1:0]        i_feature_index,
    input  wire logic [PWR_W-1:0]        i_band_power,

    // result beats
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic [IDX_W-1:0]             o_result_index,
    output logic signed [NORM_W-1:0]     o_normalized_level,
    output logic signed [DB_W-1:0]       o_level_db,

    // apb configuration
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [CFG_ADDR_W-1:0]   paddr,
    input  wire logic [31:0]             pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    logic [ALPHA_W-1:0] r_alpha;
    logic               w_cfg_wr;

    // beat flow
    logic               w_in_acc;
    logic               w_hazard;
    logic               w_pop;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   n_cnt;

    // datapath links
    t_tag               w_head;
    t_log_res           w_log;
    t_mean_res          w_mean;
    logic               w_push;
    t_out_item          w_item;

    // output queue
    t_out_item          r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_fcnt;
    logic [CNT_W-1:0]   n_fcnt;
    t_out_item          w_head_item;

    // ------------------------------------------------------------------
    // configuration: register index taken from the word address
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready
                      && (paddr[CFG_ADDR_W-1] == REG_ALPHA);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ALPHA_ONE;
        end else if (w_cfg_wr) begin
            r_alpha <= pwdata[ALPHA_W-1:0];
        end
    end

    assign prdata = (paddr[CFG_ADDR_W-1] == REG_ALPHA) ? 32'(r_alpha) : 32'h0;

    // ------------------------------------------------------------------
    // admission
    // r_cnt counts beats in flight plus beats waiting in the queue, so the
    // pipeline never has to stall: it always has a queue slot at its end.
    // a beat directly behind one with the same index would reach the mean
    // multiply while the previous update is still being summed, so it is
    // held back; two or three slots apart is covered by forwarding
    // ------------------------------------------------------------------
    assign w_hazard   = w_head.valid && (w_head.idx == i_feature_index);
    assign o_in_ready = (r_cnt < CNT_W'(FIFO_DEPTH)) && !w_hazard;
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_pop      = o_out_valid && i_out_ready;

    always_comb begin
        n_cnt = r_cnt;
        if (w_in_acc && !w_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (!w_in_acc && w_pop) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // ------------------------------------------------------------------
    // datapath: log conversion, mean read-modify-write, scale to q4.12
    // ------------------------------------------------------------------
    lpn_log u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_in_acc),
        .i_idx   (i_feature_index),
        .i_power (i_band_power),
        .o_head  (w_head),
        .o_res   (w_log)
    );

    lpn_mean u_mean (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_alpha (r_alpha),
        .i_log   (w_log),
        .o_res   (w_mean)
    );

    lpn_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mean  (w_mean),
        .o_valid (w_push),
        .o_item  (w_item)
    );

    // ------------------------------------------------------------------
    // output queue: decouples result beats from the pipeline
    // ------------------------------------------------------------------
    always_comb begin
        n_fcnt = r_fcnt;
        if (w_push && !w_pop) begin
            n_fcnt = r_fcnt + CNT_W'(1);
        end else if (!w_push && w_pop) begin
            n_fcnt = r_fcnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fcnt   <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_fcnt <= n_fcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wr_ptr] <= w_item;
        end
    end

    assign w_head_item        = r_fifo[r_rd_ptr];
    assign o_out_valid        = (r_fcnt != '0);
    assign o_result_index     = w_head_item.idx;
    assign o_normalized_level = w_head_item.norm;
    assign o_level_db         = w_head_item.db;

`ifndef ASSERT_OFF
    // beats in flight and queued never exceed the queue depth
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(FIFO_DEPTH))
        else $error("beats in flight exceed queue depth");

    // queued beats are always a subset of admitted beats
    a_queue_in_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcnt <= r_cnt)
        else $error("queue holds beats that were never admitted");

    // the log stage stays within its range from -100 dB to 25 dB
    a_db_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_level_db >= ZERO_DB) && (o_level_db <= 16'sd6400))
        else $error("level out of range");
`endif

endmodule

`default_nettype wire
